// ----- hdl/dft_pkg.sv -----
// ----------------------------------------------------------------------------
// dft_pkg
// Shared types, constants and codes for the DShot frame transmitter.
// ----------------------------------------------------------------------------
package dft_pkg;

  localparam int CMD_FIFO_DEPTH = 8;
  localparam int FIFO_AW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int FIFO_CW = $clog2(CMD_FIFO_DEPTH + 1);

  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_AW = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CW = $clog2(JOBQ_DEPTH + 1);

  localparam int OP_W = 2;
  localparam int RAW_W = 16;
  localparam int VAL_W = 11;
  localparam int CYC_W = 16;
  localparam int WORD_W = 16;
  localparam int BIT_CNT_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  localparam logic [CYC_W-1:0] HIGH_ONE_RST = 16'd15;
  localparam logic [CYC_W-1:0] LOW_ONE_RST = 16'd5;
  localparam logic [CYC_W-1:0] HIGH_ZERO_RST = 16'd8;
  localparam logic [CYC_W-1:0] LOW_ZERO_RST = 16'd12;
  localparam logic [VAL_W-1:0] THROTTLE_MIN_RST = 11'd48;
  localparam logic [VAL_W-1:0] THROTTLE_MAX_RST = 11'd2047;
  localparam logic [VAL_W-1:0] COMMAND_MIN_RST = 11'd1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_TELEM = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_ONE   = 3'd0,
    REG_LOW_ONE    = 3'd1,
    REG_HIGH_ZERO  = 3'd2,
    REG_LOW_ZERO   = 3'd3,
    REG_TELEM_ALL  = 3'd4,
    REG_THR_MIN    = 3'd5,
    REG_THR_MAX    = 3'd6,
    REG_CMD_MIN    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CYC_W-1:0] high_one;
    logic [CYC_W-1:0] low_one;
    logic [CYC_W-1:0] high_zero;
    logic [CYC_W-1:0] low_zero;
    logic             telemetry_always;
    logic [VAL_W-1:0] throttle_min;
    logic [VAL_W-1:0] throttle_max;
    logic [VAL_W-1:0] command_min;
  } cfg_t;

  typedef struct packed {
    logic              is_frame;
    logic              accepted;
    logic [WORD_W-1:0] word;
  } job_t;

endpackage

// ----- hdl/dft_cfg_if.sv -----
// ----------------------------------------------------------------------------
// dft_cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
interface dft_cfg_if;
  import dft_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/dft_req_if.sv -----
// ----------------------------------------------------------------------------
// dft_req_if
// Request channel: op code and raw value with valid/ready.
// ----------------------------------------------------------------------------
interface dft_req_if;
  import dft_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [RAW_W-1:0] raw_value;

  modport source (output valid, op, raw_value, input ready);
  modport sink (input valid, op, raw_value, output ready);
endinterface

// ----- hdl/dft_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dft_rsp_if
// Result channel: acknowledges and frame bit pulses with valid/ready.
// ----------------------------------------------------------------------------
interface dft_rsp_if;
  import dft_pkg::*;

  logic              valid;
  logic              ready;
  logic              is_bit;
  logic              accepted;
  logic              bit_value;
  logic [CYC_W-1:0]  high_width;
  logic [CYC_W-1:0]  low_width;
  logic [WORD_W-1:0] frame_word;
  logic              last;

  modport source (output valid, is_bit, accepted, bit_value, high_width, low_width,
                  frame_word, last, input ready);
  modport sink (input valid, is_bit, accepted, bit_value, high_width, low_width,
                frame_word, last, output ready);
endinterface

// ----- hdl/dft_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// dft_cfg_regs
// Configuration register file; always ready for a write.
// ----------------------------------------------------------------------------
module dft_cfg_regs (
  input  logic         clk,
  input  logic         rst,
  dft_cfg_if.sink      cfg,
  output dft_pkg::cfg_t regs
);
  import dft_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.high_one <= HIGH_ONE_RST;
      regs.low_one <= LOW_ONE_RST;
      regs.high_zero <= HIGH_ZERO_RST;
      regs.low_zero <= LOW_ZERO_RST;
      regs.telemetry_always <= 1'b0;
      regs.throttle_min <= THROTTLE_MIN_RST;
      regs.throttle_max <= THROTTLE_MAX_RST;
      regs.command_min <= COMMAND_MIN_RST;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_HIGH_ONE:  regs.high_one <= cfg.data;
        REG_LOW_ONE:   regs.low_one <= cfg.data;
        REG_HIGH_ZERO: regs.high_zero <= cfg.data;
        REG_LOW_ZERO:  regs.low_zero <= cfg.data;
        REG_TELEM_ALL: regs.telemetry_always <= cfg.data[0];
        REG_THR_MIN:   regs.throttle_min <= cfg.data[VAL_W-1:0];
        REG_THR_MAX:   regs.throttle_max <= cfg.data[VAL_W-1:0];
        REG_CMD_MIN:   regs.command_min <= cfg.data[VAL_W-1:0];
        default: begin
        end
      endcase
    end
  end
endmodule

// ----- hdl/dft_front.sv -----
// ----------------------------------------------------------------------------
// dft_front
// Sorts requests, keeps command FIFO, throttle mailbox and telemetry flag,
// and builds frame words; every request leaves one job for the back end.
// ----------------------------------------------------------------------------
module dft_front (
  input  logic          clk,
  input  logic          rst,
  input  dft_pkg::cfg_t cfg,
  dft_req_if.sink       req,
  input  logic          q_full,
  output logic          push,
  output dft_pkg::job_t push_job
);
  import dft_pkg::*;

  logic [VAL_W-1:0]   fifo [CMD_FIFO_DEPTH];
  logic [FIFO_CW-1:0] cnt, cnt_next;
  logic [FIFO_AW-1:0] rd_ptr, rd_ptr_next;
  logic [VAL_W-1:0]   mbox_value, mbox_value_next;
  logic               mbox_full, mbox_full_next;
  logic [VAL_W-1:0]   cur_value, cur_value_next;
  logic               pending, pending_next;

  logic               fifo_we;
  logic [FIFO_AW-1:0] wr_idx;
  logic [FIFO_CW:0]   wr_sum;
  logic [VAL_W-1:0]   clamped;
  logic [VAL_W-1:0]   sel_value;
  logic               telem;
  logic [11:0]        payload;
  logic [3:0]         csum;

  assign req.ready = !q_full;
  assign push = req.valid && req.ready;

  assign wr_sum = (FIFO_CW+1)'(rd_ptr) + (FIFO_CW+1)'(cnt);
  assign wr_idx = (wr_sum >= (FIFO_CW+1)'(CMD_FIFO_DEPTH))
                  ? FIFO_AW'(wr_sum - (FIFO_CW+1)'(CMD_FIFO_DEPTH))
                  : FIFO_AW'(wr_sum);
  assign clamped = (req.raw_value > RAW_W'(cfg.throttle_max))
                   ? cfg.throttle_max : req.raw_value[VAL_W-1:0];

  always_comb begin
    if (cnt != '0) begin
      sel_value = fifo[rd_ptr];
    end else if (mbox_full) begin
      sel_value = mbox_value;
    end else begin
      sel_value = cur_value;
    end
    telem = cfg.telemetry_always || pending;
    payload = {sel_value, telem};
    csum = (payload[3:0] ^ payload[7:4] ^ payload[11:8]) & NIBBLE_MASK;
  end

  always_comb begin
    cnt_next = cnt;
    rd_ptr_next = rd_ptr;
    mbox_value_next = mbox_value;
    mbox_full_next = mbox_full;
    cur_value_next = cur_value;
    pending_next = pending;
    fifo_we = 1'b0;
    push_job = '{is_frame: 1'b0, accepted: 1'b0, word: '0};
    unique case (op_t'(req.op))
      OP_WRITE: begin
        if (req.raw_value >= RAW_W'(cfg.throttle_min)) begin
          push_job.accepted = 1'b1;
          if (push) begin
            mbox_value_next = clamped;
            mbox_full_next = 1'b1;
          end
        end else if (req.raw_value >= RAW_W'(cfg.command_min)
                     && cnt != FIFO_CW'(CMD_FIFO_DEPTH)) begin
          push_job.accepted = 1'b1;
          fifo_we = push;
          if (push) begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      OP_TELEM: begin
        push_job.accepted = 1'b1;
        if (push) begin
          pending_next = 1'b1;
        end
      end
      OP_TICK: begin
        push_job.is_frame = 1'b1;
        push_job.word = {payload, csum};
        if (push) begin
          cur_value_next = sel_value;
          if (cnt != '0) begin
            cnt_next = cnt - 1'b1;
            rd_ptr_next = (rd_ptr == FIFO_AW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
          end else if (mbox_full) begin
            mbox_full_next = 1'b0;
          end
          if (!cfg.telemetry_always) begin
            pending_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd_ptr <= '0;
      mbox_full <= 1'b0;
      cur_value <= THROTTLE_MIN_RST;
      pending <= 1'b0;
    end else begin
      cnt <= cnt_next;
      rd_ptr <= rd_ptr_next;
      mbox_full <= mbox_full_next;
      cur_value <= cur_value_next;
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    mbox_value <= mbox_value_next;
    if (fifo_we) begin
      fifo[wr_idx] <= req.raw_value[VAL_W-1:0];
    end
  end
endmodule

// ----- hdl/dft_jobq.sv -----
// ----------------------------------------------------------------------------
// dft_jobq
// Short job queue between the front end and the bit serializer.
// ----------------------------------------------------------------------------
module dft_jobq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dft_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output dft_pkg::job_t head_job
);
  import dft_pkg::*;

  job_t               mem [JOBQ_DEPTH];
  logic [JOBQ_AW-1:0] wr_ptr;
  logic [JOBQ_AW-1:0] rd_ptr;
  logic [JOBQ_CW-1:0] count;

  assign full = (count == JOBQ_CW'(JOBQ_DEPTH));
  assign head_valid = (count != '0);
  assign head_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end
endmodule

// ----- hdl/dft_back.sv -----
// ----------------------------------------------------------------------------
// dft_back
// Turns jobs into results: one acknowledge, or sixteen bit pulses MSB first,
// through a registered output stage.
// ----------------------------------------------------------------------------
module dft_back (
  input  logic          clk,
  input  logic          rst,
  input  dft_pkg::cfg_t cfg,
  input  logic          head_valid,
  input  dft_pkg::job_t head_job,
  output logic          pop,
  dft_rsp_if.source     rsp
);
  import dft_pkg::*;

  logic                 active;
  logic [WORD_W-1:0]    shreg;
  logic [BIT_CNT_W-1:0] bits_left;
  logic [WORD_W-1:0]    word;
  logic                 load;
  logic                 nbit;

  assign load = (!rsp.valid || rsp.ready) && (active || head_valid);
  assign pop = load && !active;
  assign nbit = active ? shreg[WORD_W-1] : head_job.word[WORD_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
      active <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
      if (active) begin
        active <= (bits_left != BIT_CNT_W'(1));
      end else begin
        active <= head_job.is_frame;
      end
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (active) begin
        shreg <= shreg << 1;
        bits_left <= bits_left - 1'b1;
        rsp.is_bit <= 1'b1;
        rsp.accepted <= 1'b0;
        rsp.bit_value <= nbit;
        rsp.high_width <= nbit ? cfg.high_one : cfg.high_zero;
        rsp.low_width <= nbit ? cfg.low_one : cfg.low_zero;
        rsp.frame_word <= word;
        rsp.last <= (bits_left == BIT_CNT_W'(1));
      end else if (head_job.is_frame) begin
        word <= head_job.word;
        shreg <= head_job.word << 1;
        bits_left <= BIT_CNT_W'(WORD_W - 1);
        rsp.is_bit <= 1'b1;
        rsp.accepted <= 1'b0;
        rsp.bit_value <= nbit;
        rsp.high_width <= nbit ? cfg.high_one : cfg.high_zero;
        rsp.low_width <= nbit ? cfg.low_one : cfg.low_zero;
        rsp.frame_word <= head_job.word;
        rsp.last <= 1'b0;
      end else begin
        rsp.is_bit <= 1'b0;
        rsp.accepted <= head_job.accepted;
        rsp.bit_value <= 1'b0;
        rsp.high_width <= '0;
        rsp.low_width <= '0;
        rsp.frame_word <= '0;
        rsp.last <= 1'b1;
      end
    end
  end
endmodule

// ----- hdl/dshot_frame_transmitter.sv -----
// ----------------------------------------------------------------------------
// dshot_frame_transmitter
// DShot command transmitter: request sorting, frame building, bit pulses.
// ----------------------------------------------------------------------------
// Channels: cfg writes one of eight registers (pulse widths, telemetry mode,
// throttle and command limits) and is always ready. req takes a value write,
// a telemetry-once request or a frame tick. rsp returns one acknowledge per
// write, request or unused op, and sixteen bit words per frame tick, MSB
// first, each with its high and low cycle counts and the whole frame word.
// A taken req word goes into the job queue, and the back end then loads it
// into the registered output stage. req takes one word per cycle while the
// queue is not full; acknowledges leave at one per cycle while rsp.ready is
// high; a frame fills rsp with sixteen bit words. The four-entry job queue
// between front end and serializer lets req flow during a frame until full.
// Reset: registers return to their defaults, FIFO and mailbox are empty,
// the value sent by an idle tick is 48, and rsp goes invalid.
// When the receiver holds rsp.ready low the output word holds steady and
// the queue fills, then req.ready drops.
// ----------------------------------------------------------------------------
module dshot_frame_transmitter (
  input  logic      clk,
  input  logic      rst,
  dft_cfg_if.sink   cfg,
  dft_req_if.sink   req,
  dft_rsp_if.source rsp
);
  import dft_pkg::*;

  cfg_t regs;
  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  logic head_valid;
  job_t head_job;

  dft_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  dft_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (regs),
    .req      (req),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  dft_jobq u_jobq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  dft_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (regs),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .rsp        (rsp)
  );
endmodule

// ----- hdl/dft_checker.sv -----
// ----------------------------------------------------------------------------
// dft_port_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dft_port_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic                      is_bit,
  input logic                      accepted,
  input logic                      bit_value,
  input logic [dft_pkg::CYC_W-1:0]  high_width,
  input logic [dft_pkg::CYC_W-1:0]  low_width,
  input logic [dft_pkg::WORD_W-1:0] frame_word,
  input logic                      last
);
  import dft_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid
      && $stable({is_bit, accepted, bit_value, high_width, low_width, frame_word, last}))
    else $error("stalled rsp word changed");

  a_ack_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !is_bit |-> last && !bit_value && high_width == '0
      && low_width == '0 && frame_word == '0)
    else $error("malformed acknowledge");

  a_frame_csum: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_bit |-> !accepted
      && frame_word[3:0] == (frame_word[15:12] ^ frame_word[11:8] ^ frame_word[7:4]))
    else $error("bad frame checksum");
endmodule

bind dshot_frame_transmitter dft_port_checker u_dft_port_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .is_bit     (rsp.is_bit),
  .accepted   (rsp.accepted),
  .bit_value  (rsp.bit_value),
  .high_width (rsp.high_width),
  .low_width  (rsp.low_width),
  .frame_word (rsp.frame_word),
  .last       (rsp.last)
);

// ----- verif/dft_checker.sv -----
// ----------------------------------------------------------------------------
// dft_checker
// Tracks cfg and req words, predicts every rsp word of the DShot frame
// transmitter and compares the actual rsp words in order, field by field.
// ----------------------------------------------------------------------------
module dft_checker
  import dft_pkg::*;
(
  input  logic clk,
  input  logic rst,
  dft_cfg_if   cfg,
  dft_req_if   req,
  dft_rsp_if   rsp,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              is_bit;
    logic              accepted;
    logic              bit_value;
    logic [CYC_W-1:0]  high_width;
    logic [CYC_W-1:0]  low_width;
    logic [WORD_W-1:0] frame_word;
    logic              last;
  } rsp_word_t;

  cfg_t             regs;
  logic [VAL_W-1:0] cmd_fifo[$];
  logic [VAL_W-1:0] mbox_value;
  logic             mbox_full;
  logic [VAL_W-1:0] sent_value;
  logic             once_pending;
  rsp_word_t        expected_words[$];
  rsp_word_t        got_word;
  rsp_word_t        exp_word;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // throttle goes to the mailbox, commands to the FIFO
  function automatic logic sort_write(input logic [RAW_W-1:0] raw);
    if (raw >= regs.throttle_min) begin
      mbox_value = (raw > regs.throttle_max) ? regs.throttle_max : raw[VAL_W-1:0];
      mbox_full  = 1'b1;
      return 1'b1;
    end
    if (raw < regs.command_min || cmd_fifo.size() >= CMD_FIFO_DEPTH) return 1'b0;
    cmd_fifo.push_back(raw[VAL_W-1:0]);
    return 1'b1;
  endfunction

  function automatic void predict_words(input logic [OP_W-1:0] op,
                                        input logic [RAW_W-1:0] raw);
    rsp_word_t         w;
    logic              telem;
    logic [VAL_W:0]    payload;
    logic [WORD_W-1:0] frame;
    w = '0;
    w.last = 1'b1;
    case (op)
      OP_WRITE: begin
        w.accepted = sort_write(raw);
        expected_words.push_back(w);
      end
      OP_TELEM: begin
        once_pending = 1'b1;
        w.accepted = 1'b1;
        expected_words.push_back(w);
      end
      OP_TICK: begin
        if (cmd_fifo.size() != 0) begin
          sent_value = cmd_fifo.pop_front();
        end else if (mbox_full) begin
          sent_value = mbox_value;
          mbox_full  = 1'b0;
        end
        telem = regs.telemetry_always | once_pending;
        if (!regs.telemetry_always) once_pending = 1'b0;
        payload = {sent_value, telem};
        frame   = {payload, payload[3:0] ^ payload[7:4] ^ payload[11:8]};
        for (int k = WORD_W - 1; k >= 0; k--) begin
          w.is_bit     = 1'b1;
          w.accepted   = 1'b0;
          w.bit_value  = frame[k];
          w.high_width = frame[k] ? regs.high_one : regs.high_zero;
          w.low_width  = frame[k] ? regs.low_one : regs.low_zero;
          w.frame_word = frame;
          w.last       = (k == 0);
          expected_words.push_back(w);
        end
      end
      default: expected_words.push_back(w);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs = '{high_one: HIGH_ONE_RST, low_one: LOW_ONE_RST,
               high_zero: HIGH_ZERO_RST, low_zero: LOW_ZERO_RST,
               telemetry_always: 1'b0, throttle_min: THROTTLE_MIN_RST,
               throttle_max: THROTTLE_MAX_RST, command_min: COMMAND_MIN_RST};
      cmd_fifo.delete();
      expected_words.delete();
      mbox_value   = '0;
      mbox_full    = 1'b0;
      sent_value   = THROTTLE_MIN_RST;
      once_pending = 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got_word = '{rsp.is_bit, rsp.accepted, rsp.bit_value, rsp.high_width,
                     rsp.low_width, rsp.frame_word, rsp.last};
        if (expected_words.size() == 0) begin
          if (mismatches < 10)
            $display("rsp word with nothing pending: is_bit=%b acc=%b word=%h last=%b",
                     got_word.is_bit, got_word.accepted, got_word.frame_word, got_word.last);
          mismatches++;
        end else begin
          exp_word = expected_words.pop_front();
          if (got_word !== exp_word) begin
            if (mismatches < 10) begin
              $display("rsp mismatch exp: is_bit=%b acc=%b bit=%b hi=%0d lo=%0d word=%h last=%b",
                       exp_word.is_bit, exp_word.accepted, exp_word.bit_value,
                       exp_word.high_width, exp_word.low_width, exp_word.frame_word,
                       exp_word.last);
              $display("             got: is_bit=%b acc=%b bit=%b hi=%0d lo=%0d word=%h last=%b",
                       got_word.is_bit, got_word.accepted, got_word.bit_value,
                       got_word.high_width, got_word.low_width, got_word.frame_word,
                       got_word.last);
            end
            mismatches++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (reg_idx_t'(cfg.index))
          REG_HIGH_ONE:  regs.high_one = cfg.data;
          REG_LOW_ONE:   regs.low_one = cfg.data;
          REG_HIGH_ZERO: regs.high_zero = cfg.data;
          REG_LOW_ZERO:  regs.low_zero = cfg.data;
          REG_TELEM_ALL: regs.telemetry_always = cfg.data[0];
          REG_THR_MIN:   regs.throttle_min = cfg.data[VAL_W-1:0];
          REG_THR_MAX:   regs.throttle_max = cfg.data[VAL_W-1:0];
          REG_CMD_MIN:   regs.command_min = cfg.data[VAL_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) predict_words(req.op, req.raw_value);
    end
    outstanding = expected_words.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives register writes, value writes, telemetry requests and frame ticks
// into the DShot frame transmitter with random idling on both sides and two
// long rsp stalls; dft_checker predicts and checks every rsp word.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dft_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 120;
  localparam int MAX_VAL = 2047;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   thr_min;
  int   thr_max;
  int   cmd_min;
  bit   gap_free;
  int   hold_asked;
  int   hold_taken;
  int   rnd_min;
  int   rnd_max;

  dft_cfg_if cfg_ch ();
  dft_req_if req_ch ();
  dft_rsp_if rsp_ch ();

  dshot_frame_transmitter u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  dft_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_ch),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3000000;
    $display("tb_top NOT OK");
    $finish;
  end

  // rsp side: random stall per word, long hold when asked
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    hold_taken = 0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = gap_free ? 0 : $urandom_range(0, 3);
      if (hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_req(input logic [OP_W-1:0] op, input logic [RAW_W-1:0] raw);
    int gap;
    gap = gap_free ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.raw_value <= raw;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int unsigned value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic apply_config(input int unsigned hi_one, input int unsigned lo_one,
                              input int unsigned hi_zero, input int unsigned lo_zero,
                              input int unsigned telem, input int tmin, input int tmax,
                              input int cmin);
    write_reg(REG_HIGH_ONE, hi_one);
    write_reg(REG_LOW_ONE, lo_one);
    write_reg(REG_HIGH_ZERO, hi_zero);
    write_reg(REG_LOW_ZERO, lo_zero);
    write_reg(REG_TELEM_ALL, telem);
    write_reg(REG_THR_MIN, tmin);
    write_reg(REG_THR_MAX, tmax);
    write_reg(REG_CMD_MIN, cmin);
    cfg_ch.valid <= 1'b0;
    thr_min = tmin;
    thr_max = tmax;
    cmd_min = cmin;
  endtask

  // drop req and wait for every pending rsp word
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [RAW_W-1:0] pick_raw();
    int unsigned sel;
    int          v;
    sel = $urandom_range(0, 9);
    case (sel)
      0: v = $urandom_range(0, 65535);
      1, 2, 3: v = (cmd_min < thr_min) ? $urandom_range(cmd_min, thr_min - 1)
                                       : $urandom_range(0, 65535);
      4, 5, 6: v = $urandom_range(thr_min, MAX_VAL);
      7: begin
        case ($urandom_range(0, 5))
          0: v = cmd_min - 1;
          1: v = cmd_min;
          2: v = thr_min - 1;
          3: v = thr_min;
          4: v = thr_max;
          default: v = thr_max + 1;
        endcase
        if (v < 0) v = 0;
      end
      8: v = (cmd_min > 0) ? $urandom_range(0, cmd_min - 1) : 0;
      default: v = $urandom_range(MAX_VAL + 1, 65535);
    endcase
    return RAW_W'(v);
  endfunction

  task automatic random_items(input int count, input bit with_hold);
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      gap_free = (i >= count / 2) && (i < count / 2 + 16);
      if (with_hold && i == 20) hold_asked++;
      pick = $urandom_range(0, 99);
      if (pick < 42) send_req(OP_WRITE, pick_raw());
      else if (pick < 50) send_req(OP_TELEM, RAW_W'($urandom));
      else if (pick < 95) send_req(OP_TICK, RAW_W'($urandom));
      else send_req(OP_UNUSED, RAW_W'($urandom));
    end
    gap_free = 1'b0;
  endtask

  initial begin
    rst              = 1'b1;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    req_ch.valid     = 1'b0;
    req_ch.op        = '0;
    req_ch.raw_value = '0;
    gap_free         = 1'b0;
    hold_asked       = 0;
    thr_min          = THROTTLE_MIN_RST;
    thr_max          = THROTTLE_MAX_RST;
    cmd_min          = COMMAND_MIN_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults: idle tick, telemetry once, reject, clamp, command priority
    send_req(OP_TICK, 16'h0000);
    send_req(OP_TELEM, 16'h0000);
    send_req(OP_TICK, 16'hFFFF);
    send_req(OP_TICK, 16'h0000);
    send_req(OP_WRITE, 16'd0);
    send_req(OP_WRITE, 16'hFFFF);
    send_req(OP_TICK, 16'h0000);
    send_req(OP_WRITE, 16'd48);
    send_req(OP_WRITE, 16'd47);
    send_req(OP_TICK, 16'h0000);
    send_req(OP_TICK, 16'h0000);
    send_req(OP_TICK, 16'h0000);
    // FIFO fills, ninth command rejected
    for (int v = 1; v <= CMD_FIFO_DEPTH + 1; v++) send_req(OP_WRITE, RAW_W'(v));
    send_req(OP_UNUSED, 16'hFFFF);
    send_req(OP_TICK, 16'h0000);
    send_req(OP_WRITE, 16'd1000);
    send_req(OP_TICK, 16'h0000);
    random_items(90, 1'b1);
    settle();

    // extreme widths, telemetry always on, crossed throttle limits
    apply_config(65535, 1, 1, 65535, 1, MAX_VAL, 0, 0);
    send_req(OP_TELEM, 16'h0000);
    send_req(OP_TICK, 16'h0000);
    send_req(OP_WRITE, 16'd0);
    send_req(OP_WRITE, 16'd2047);
    send_req(OP_WRITE, 16'hFFFF);
    send_req(OP_TICK, 16'h0000);
    send_req(OP_TICK, 16'h0000);
    random_items(80, 1'b0);
    settle();

    // everything is throttle, no command range
    apply_config(1, 65535, 65535, 1, 0, 0, MAX_VAL, MAX_VAL);
    send_req(OP_TICK, 16'h0000);
    random_items(80, 1'b1);
    settle();

    rnd_min = $urandom_range(0, MAX_VAL);
    rnd_max = $urandom_range(0, MAX_VAL);
    apply_config($urandom_range(1, 65535), $urandom_range(1, 65535),
                 $urandom_range(1, 65535), $urandom_range(1, 65535),
                 $urandom_range(0, 1), rnd_min, rnd_max, $urandom_range(0, rnd_min));
    random_items(80, 1'b0);
    settle();
    repeat (20) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/dft_pkg.sv
hdl/dft_cfg_if.sv
hdl/dft_req_if.sv
hdl/dft_rsp_if.sv
hdl/dft_cfg_regs.sv
hdl/dft_front.sv
hdl/dft_jobq.sv
hdl/dft_back.sv
hdl/dshot_frame_transmitter.sv
hdl/dft_checker.sv
verif/dft_checker.sv
verif/tb_top.sv
